// File: src/sre_pkg.sv
package sre_pkg;

  // default sizes
  localparam int DATA_DEPTH_DEF = 1024;
  localparam int PROG_DEPTH_DEF = 1024;
  localparam int REG_COUNT      = 32;
  localparam int RIDX_W         = 5;

  // host commands
  localparam logic [1:0] CMD_WDATA = 2'd0;
  localparam logic [1:0] CMD_WREG  = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  // opcodes
  localparam logic [4:0] OP_STOP  = 5'd0;
  localparam logic [4:0] OP_ADD   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_MUL   = 5'd3;
  localparam logic [4:0] OP_DIV   = 5'd4;
  localparam logic [4:0] OP_AND   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_XOR   = 5'd7;
  localparam logic [4:0] OP_SHL   = 5'd8;
  localparam logic [4:0] OP_SHR   = 5'd9;
  localparam logic [4:0] OP_SLT   = 5'd10;
  localparam logic [4:0] OP_SLE   = 5'd11;
  localparam logic [4:0] OP_SEQ   = 5'd12;
  localparam logic [4:0] OP_LOAD  = 5'd13;
  localparam logic [4:0] OP_STORE = 5'd14;
  localparam logic [4:0] OP_JMP   = 5'd15;
  localparam logic [4:0] OP_BRAZ  = 5'd16;
  localparam logic [4:0] OP_BRANZ = 5'd17;

  // fault codes
  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_DIV0 = 2'd1;
  localparam logic [1:0] FLT_ADDR = 2'd2;

  // cost units
  localparam logic [47:0] COST_ALU    = 48'd1;
  localparam logic [47:0] COST_MULDIV = 48'd2;
  localparam logic [47:0] COST_MEM    = 48'd100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RA,
    S_RB,
    S_RC,
    S_EXEC,
    S_DIV,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic              we;
    logic [RIDX_W-1:0] addr;
    logic [31:0]       data;
  } rf_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

// File: src/small_risc_execute_unit.sv
// channel  | handshake          | payload
// input    | in_valid, in_stall  | command, address, value, instruction
// output   | out_valid, out_stall| next_pc, halted, reg_written, dest_reg,
//          |                     | dest_value, cost_total, fault
//
// an item is accepted in IDLE, then RA, RB and RC make three register file reads through
// the single read port and EXEC registers the result; no new item is accepted until then
// loads add a data memory read state, divides wait on the divider (one bit a cycle)
// synchronous active-high reset clears pc, halt, cost and register valid bits
// a stalled result holds the last stage until the output register is free
// depths must be powers of two; the block itself does not enforce this
module small_risc_execute_unit import sre_pkg::*; #(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [9:0]         address,
  input  logic signed [31:0] value,
  input  logic [31:0]        instruction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         next_pc,
  output logic               halted,
  output logic               reg_written,
  output logic [4:0]         dest_reg,
  output logic signed [31:0] dest_value,
  output logic [47:0]        cost_total,
  output logic [1:0]         fault
);

  localparam int DW = $clog2(DATA_DEPTH);
  localparam int PW = $clog2(PROG_DEPTH);

  state_t state, state_next;

  logic [1:0]  cmd_q;
  logic [9:0]  addr_q;
  logic [31:0] val_q;
  logic [31:0] ins_q;
  logic [31:0] x_q;
  logic [31:0] opb_q;
  logic [31:0] rbv_q;

  logic [PW-1:0] pc;
  logic          halt_flag;
  logic [47:0]   cost;

  logic [31:0] dmem [DATA_DEPTH];
  logic [31:0] dm_rdata;

  logic [RIDX_W-1:0] rf_raddr;
  logic [31:0]       rf_rdata;
  rf_wr_t            rf_wr;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // decode
  logic [4:0]    op;
  logic [31:0]   opnd;
  logic [32:0]   ea;
  logic          ea_ok;
  logic [PW-1:0] pc_inc;
  logic          running;
  logic          going_div;
  logic          going_load;
  logic          out_free;

  // finishing values
  logic          fin_go;
  logic          fin_wr;
  logic [4:0]    fin_rd;
  logic [31:0]   fin_rv;
  logic [1:0]    fin_fault;
  logic [47:0]   fin_cost;
  logic [PW-1:0] fin_pc;
  logic          fin_halt;
  logic          fin_mw;
  logic [DW-1:0] fin_maddr;
  logic [31:0]   fin_mdata;
  logic          commit;

  sre_regfile u_rf (
    .clk   (clk),
    .rst   (rst),
    .raddr (rf_raddr),
    .rdata (rf_rdata),
    .wr    (rf_wr)
  );

  sre_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign op       = ins_q[31:27];
  assign opnd     = ins_q[21] ? {16'd0, ins_q[20:5]} : opb_q;
  assign ea       = {x_q[31], x_q} + {opnd[31], opnd};
  assign ea_ok    = !ea[32] && (ea[31:0] < 32'(DATA_DEPTH));
  assign pc_inc   = pc + PW'(1);
  assign running  = (cmd_q == CMD_EXEC) && !halt_flag;
  assign going_div  = (state == S_EXEC) && running && (op == OP_DIV) && (opnd != 32'd0);
  assign going_load = (state == S_EXEC) && running && (op == OP_LOAD) && ea_ok;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_RA;
      S_RA:   state_next = S_RB;
      S_RB:   state_next = S_RC;
      S_RC:   state_next = S_EXEC;
      S_EXEC: begin
        if (going_div) state_next = S_DIV;
        else if (going_load) state_next = S_LOAD;
        else if (out_free) state_next = S_IDLE;
      end
      S_DIV:  if (div_rsp.done && out_free) state_next = S_IDLE;
      S_LOAD: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    rf_raddr = ins_q[4:0];
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        rf_raddr = instruction[26:22];
      end
      S_RA:    rf_raddr = ins_q[9:5];
      S_RB:    rf_raddr = ins_q[4:0];
      default: rf_raddr = ins_q[4:0];
    endcase
    div_req.start = going_div;
    div_req.a     = x_q;
    div_req.b     = opnd;
  end

  // result of the item
  always_comb begin
    fin_go    = 1'b0;
    fin_wr    = 1'b0;
    fin_rd    = '0;
    fin_rv    = '0;
    fin_fault = FLT_NONE;
    fin_cost  = '0;
    fin_pc    = pc;
    fin_halt  = halt_flag;
    fin_mw    = 1'b0;
    fin_maddr = ea[DW-1:0];
    fin_mdata = rbv_q;
    case (state)
      S_EXEC: begin
        fin_go = !going_div && !going_load;
        case (cmd_q)
          CMD_WDATA: begin
            fin_maddr = DW'(addr_q);
            fin_mdata = val_q;
            if (32'(addr_q) < 32'(DATA_DEPTH)) fin_mw = 1'b1;
            else fin_fault = FLT_ADDR;
          end
          CMD_WREG: begin
            if (addr_q[9:5] == 5'd0) begin
              fin_wr = 1'b1;
              fin_rd = addr_q[4:0];
              fin_rv = val_q;
            end
          end
          CMD_EXEC: begin
            if (!halt_flag) begin
              fin_pc = pc_inc;
              fin_rd = ins_q[4:0];
              case (op)
                OP_ADD: begin fin_wr = 1'b1; fin_rv = x_q + opnd; fin_cost = COST_ALU; end
                OP_SUB: begin fin_wr = 1'b1; fin_rv = x_q - opnd; fin_cost = COST_ALU; end
                OP_MUL: begin
                  fin_wr = 1'b1; fin_rv = 32'(x_q * opnd); fin_cost = COST_MULDIV;
                end
                OP_DIV: fin_fault = FLT_DIV0;
                OP_AND: begin fin_wr = 1'b1; fin_rv = x_q & opnd; fin_cost = COST_ALU; end
                OP_OR:  begin fin_wr = 1'b1; fin_rv = x_q | opnd; fin_cost = COST_ALU; end
                OP_XOR: begin fin_wr = 1'b1; fin_rv = x_q ^ opnd; fin_cost = COST_ALU; end
                OP_SHL: begin
                  fin_wr = 1'b1; fin_rv = x_q << opnd[4:0]; fin_cost = COST_ALU;
                end
                OP_SHR: begin
                  fin_wr = 1'b1; fin_rv = $signed(x_q) >>> opnd[4:0]; fin_cost = COST_ALU;
                end
                OP_SLT: begin
                  fin_wr = 1'b1; fin_rv = {31'd0, $signed(x_q) < $signed(opnd)};
                  fin_cost = COST_ALU;
                end
                OP_SLE: begin
                  fin_wr = 1'b1; fin_rv = {31'd0, $signed(x_q) <= $signed(opnd)};
                  fin_cost = COST_ALU;
                end
                OP_SEQ: begin
                  fin_wr = 1'b1; fin_rv = {31'd0, x_q == opnd}; fin_cost = COST_ALU;
                end
                OP_LOAD: fin_fault = FLT_ADDR;
                OP_STORE: begin
                  if (ea_ok) begin
                    fin_mw   = 1'b1;
                    fin_cost = COST_MEM;
                  end else begin
                    fin_fault = FLT_ADDR;
                  end
                end
                OP_JMP: begin
                  fin_wr = 1'b1;
                  fin_rv = 32'(pc_inc);
                  if (ins_q[26]) fin_pc = PW'(ins_q[25:5]);
                  else if (ins_q[4:0] == ins_q[9:5]) fin_pc = pc_inc;
                  else fin_pc = PW'(opb_q);
                end
                OP_BRAZ:  if (x_q == 32'd0) fin_pc = PW'(ins_q[21:0]);
                OP_BRANZ: if (x_q != 32'd0) fin_pc = PW'(ins_q[21:0]);
                OP_STOP:  fin_halt = 1'b1;
                default:  fin_rd = '0;
              endcase
              if (!fin_wr) fin_rd = '0;
            end
          end
          default: fin_go = 1'b1;
        endcase
      end
      S_DIV: begin
        fin_go   = div_rsp.done;
        fin_pc   = pc_inc;
        fin_wr   = 1'b1;
        fin_rd   = ins_q[4:0];
        fin_rv   = div_rsp.quo;
        fin_cost = COST_MULDIV;
      end
      S_LOAD: begin
        fin_go   = 1'b1;
        fin_pc   = pc_inc;
        fin_wr   = 1'b1;
        fin_rd   = ins_q[4:0];
        fin_rv   = dm_rdata;
        fin_cost = COST_MEM;
      end
      default: fin_go = 1'b0;
    endcase
  end

  assign commit      = fin_go && out_free;
  assign rf_wr.we    = commit && fin_wr;
  assign rf_wr.addr  = fin_rd;
  assign rf_wr.data  = fin_rv;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      halt_flag <= 1'b0;
      cost      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        pc        <= fin_pc;
        halt_flag <= fin_halt;
        cost      <= cost + fin_cost;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // beat capture and operand latches
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q  <= command;
      addr_q <= address;
      val_q  <= value;
      ins_q  <= instruction;
    end
    if (state == S_RA) x_q <= rf_rdata;
    if (state == S_RB) opb_q <= rf_rdata;
    if (state == S_RC) rbv_q <= rf_rdata;
  end

  // output register
  always_ff @(posedge clk) begin
    if (commit) begin
      next_pc     <= 10'(fin_pc);
      halted      <= fin_halt;
      reg_written <= fin_wr;
      dest_reg    <= fin_rd;
      dest_value  <= fin_rv;
      cost_total  <= cost + fin_cost;
      fault       <= fin_fault;
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (commit && fin_mw) begin
      dmem[fin_maddr] <= fin_mdata;
    end
    if (going_load) begin
      dm_rdata <= dmem[ea[DW-1:0]];
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_dest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reg_written) |-> (dest_reg == 5'd0 && dest_value == 32'sd0))
    else $error("dest fields set without a register write");

  a_fault_nowrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault != FLT_NONE) |-> !reg_written)
    else $error("register written on a faulting beat");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && halted) |=> halt_flag)
    else $error("halt flag cleared after a halted beat");

  a_div_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");
`endif

endmodule

// File: src/sre_regfile.sv
module sre_regfile import sre_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [RIDX_W-1:0] raddr,
  output logic [31:0]       rdata,
  input  rf_wr_t            wr
);

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [31:0]          rdata_q;
  logic                 vld_q;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_q <= mem[raddr];
  end

  // per-entry valid bits, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      vld_q <= valid[raddr];
    end
  end

  assign rdata = vld_q ? rdata_q : 32'd0;

endmodule

// File: src/sre_divider.sv
module sre_divider import sre_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] trial;
  logic        fits;

  // one quotient bit per cycle on magnitudes
  assign trial = {rem, quo[31]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == 5'd31) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= '0;
      rem <= '0;
      quo <= req.a[31] ? 32'(-req.a) : req.a;
      dvs <= req.b[31] ? 32'(-req.b) : req.b;
      neg <= req.a[31] ^ req.b[31];
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      rem <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quo <= {quo[30:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = neg ? 32'(-quo) : quo;

endmodule

// File: sim/sre_checker.sv
`timescale 1ns / 100ps
module sre_checker import sre_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         command,
  input  logic [9:0]         address,
  input  logic signed [31:0] value,
  input  logic [31:0]        instruction,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [9:0]         next_pc,
  input  logic               halted,
  input  logic               reg_written,
  input  logic [4:0]         dest_reg,
  input  logic signed [31:0] dest_value,
  input  logic [47:0]        cost_total,
  input  logic [1:0]         fault,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [9:0]  pc;
    logic        halt;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] rv;
    logic [47:0] cost;
    logic [1:0]  flt;
  } outcome_t;

  logic [31:0] regs [REG_COUNT];
  logic [31:0] dmem [DATA_DEPTH_DEF];
  logic [9:0]  pc_q;
  logic        halt_q;
  logic [47:0] cost_q;
  outcome_t    expected_q [$];

  // architectural effect of one accepted beat
  function automatic outcome_t execute_beat(logic [1:0] cmd, logic [9:0] adr,
                                            logic [31:0] val, logic [31:0] ins);
    outcome_t    o;
    logic [4:0]  op, ra, rb;
    logic [31:0] opnd, x, res;
    logic [47:0] cost;
    logic        alu;
    longint      ea;
    o = '0;
    if (cmd == CMD_WDATA) begin
      dmem[adr] = val;
    end else if (cmd == CMD_WREG) begin
      if (adr < REG_COUNT) begin
        regs[adr[4:0]] = val;
        o.wr = 1'b1; o.rd = adr[4:0]; o.rv = val;
      end
    end else if (cmd == CMD_EXEC && !halt_q) begin
      op   = ins[31:27];
      ra   = ins[26:22];
      rb   = ins[4:0];
      opnd = ins[21] ? {16'd0, ins[20:5]} : regs[ins[9:5]];
      x    = regs[ra];
      res  = '0;
      cost = COST_ALU;
      alu  = 1'b1;
      pc_q = pc_q + 10'd1;
      case (op)
        OP_ADD: res = x + opnd;
        OP_SUB: res = x - opnd;
        OP_MUL: begin res = x * opnd; cost = COST_MULDIV; end
        OP_DIV: begin
          cost = COST_MULDIV;
          if (opnd == 0) begin o.flt = FLT_DIV0; alu = 1'b0; end
          else if (x == 32'h8000_0000 && opnd == 32'hffff_ffff) res = x;
          else res = $signed(x) / $signed(opnd);
        end
        OP_AND: res = x & opnd;
        OP_OR:  res = x | opnd;
        OP_XOR: res = x ^ opnd;
        OP_SHL: res = x << opnd[4:0];
        OP_SHR: res = $signed(x) >>> opnd[4:0];
        OP_SLT: res = {31'd0, $signed(x) < $signed(opnd)};
        OP_SLE: res = {31'd0, $signed(x) <= $signed(opnd)};
        OP_SEQ: res = {31'd0, x == opnd};
        OP_LOAD, OP_STORE: begin
          ea  = longint'($signed(opnd)) + longint'($signed(x));
          alu = 1'b0;
          if (ea < 0 || ea >= DATA_DEPTH_DEF) o.flt = FLT_ADDR;
          else if (op == OP_LOAD) begin
            res = dmem[ea]; alu = 1'b1; cost = COST_MEM;
          end else begin
            dmem[ea] = regs[rb];
            cost_q = cost_q + COST_MEM;
          end
        end
        OP_JMP: begin
          regs[rb] = {22'd0, pc_q};
          o.wr = 1'b1; o.rd = rb; o.rv = {22'd0, pc_q};
          alu = 1'b0;
          pc_q = ins[26] ? ins[14:5] : regs[ins[9:5]][9:0];
        end
        OP_BRAZ, OP_BRANZ: begin
          alu = 1'b0;
          if ((x == 0) == (op == OP_BRAZ)) pc_q = ins[9:0];
        end
        OP_STOP: begin halt_q = 1'b1; alu = 1'b0; end
        default: alu = 1'b0;
      endcase
      if (alu) begin
        regs[rb] = res;
        o.wr = 1'b1; o.rd = rb; o.rv = res;
        cost_q = cost_q + cost;
      end
    end
    o.pc   = pc_q;
    o.halt = halt_q;
    o.cost = cost_q;
    return o;
  endfunction

  // predict on input beats, compare on output beats
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      pc_q = '0; halt_q = 1'b0; cost_q = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(execute_beat(command, address, value, instruction));
      if (out_valid && !out_stall) begin
        got = '{next_pc, halted, reg_written, dest_reg, dest_value, cost_total, fault};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.pc !== want.pc) begin
            $display("%0t: next_pc exp %h got %h", $time, want.pc, got.pc); fail_count++;
          end
          if (got.halt !== want.halt) begin
            $display("%0t: halted exp %h got %h", $time, want.halt, got.halt); fail_count++;
          end
          if (got.wr !== want.wr) begin
            $display("%0t: reg_written exp %h got %h", $time, want.wr, got.wr); fail_count++;
          end
          if (got.rd !== want.rd) begin
            $display("%0t: dest_reg exp %h got %h", $time, want.rd, got.rd); fail_count++;
          end
          if (got.rv !== want.rv) begin
            $display("%0t: dest_value exp %h got %h", $time, want.rv, got.rv); fail_count++;
          end
          if (got.cost !== want.cost) begin
            $display("%0t: cost_total exp %h got %h", $time, want.cost, got.cost); fail_count++;
          end
          if (got.flt !== want.flt) begin
            $display("%0t: fault exp %h got %h", $time, want.flt, got.flt); fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
module tb import sre_pkg::*;;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         command;
  logic [9:0]         address;
  logic signed [31:0] value;
  logic [31:0]        instruction;
  logic               out_valid;
  logic               out_stall;
  logic [9:0]         next_pc;
  logic               halted;
  logic               reg_written;
  logic [4:0]         dest_reg;
  logic signed [31:0] dest_value;
  logic [47:0]        cost_total;
  logic [1:0]         fault;
  int                 fail_count;
  int                 pending;
  int                 cycle_count;
  logic               calm;
  logic               hold_request;
  logic               written [DATA_DEPTH_DEF];

  small_risc_execute_unit dut (.*);

  sre_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // drive one beat and hold it until accepted
  task automatic send_beat(logic [1:0] cmd, logic [9:0] adr, logic [31:0] val,
                           logic [31:0] ins);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; command <= cmd; address <= adr; value <= val; instruction <= ins;
    if (cmd == CMD_WDATA) written[adr] = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] encode(logic [4:0] op, logic [4:0] ra, logic imm,
                                         logic [15:0] k, logic [4:0] rb);
    return {op, ra, imm, k, rb};
  endfunction

  // random instruction; loads only touch written words
  function automatic logic [31:0] random_instruction();
    logic [4:0]  op;
    logic [31:0] w;
    op = $urandom_range(100) < 3 ? 5'($urandom_range(31)) : 5'($urandom_range(17, 1));
    w  = $urandom;
    w[31:27] = op;
    if (op == OP_LOAD) begin
      // register 0 is kept at zero base for loads
      w[26:22] = 5'd0; w[21] = 1'b1;
      w[20:5] = 16'($urandom_range(15));
      if (!written[w[14:5]]) w[20:5] = 16'd0;
      if ($urandom_range(9) == 0) w[20:5] = 16'd2000;
    end
    if (op == OP_STOP && $urandom_range(3) != 0) w[31:27] = OP_ADD;
    if (w[4:0] == 5'd0 && op != OP_STORE && op != OP_BRAZ && op != OP_BRANZ)
      w[4:0] = 5'd1;
    return w;
  endfunction

  // receiver stalls, with a quiet stretch and one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && $urandom_range(99) < 22;
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int k;
    rst = 1'b1; in_valid = 1'b0; command = '0; address = '0; value = '0;
    instruction = '0; calm = 1'b0; hold_request = 1'b0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes and special cases
    send_beat(CMD_WDATA, 10'd0, 32'h8000_0000, '0);
    send_beat(CMD_WDATA, 10'd1023, 32'h7fff_ffff, '0);
    send_beat(CMD_WREG, 10'd1, 32'h8000_0000, '0);
    send_beat(CMD_WREG, 10'd2, 32'hffff_ffff, '0);
    send_beat(CMD_WREG, 10'd1023, 32'h1234_5678, '0);
    send_beat(2'd3, 10'd5, 32'h1, 32'hffff_ffff);
    send_beat(CMD_EXEC, '0, '0, {OP_DIV, 5'd1, 1'b0, 11'd0, 5'd2, 5'd3});
    send_beat(CMD_EXEC, '0, '0, {OP_DIV, 5'd1, 1'b0, 11'd0, 5'd4, 5'd3});
    send_beat(CMD_EXEC, '0, '0, encode(OP_SHL, 5'd2, 1'b1, 16'hffff, 5'd5));
    send_beat(CMD_EXEC, '0, '0, encode(OP_SHR, 5'd1, 1'b1, 16'd33, 5'd6));
    send_beat(CMD_EXEC, '0, '0, encode(OP_LOAD, 5'd0, 1'b1, 16'd1023, 5'd7));
    send_beat(CMD_EXEC, '0, '0, encode(OP_LOAD, 5'd0, 1'b1, 16'd1024, 5'd7));
    send_beat(CMD_EXEC, '0, '0, encode(OP_STORE, 5'd1, 1'b1, 16'd5, 5'd7));
    send_beat(CMD_EXEC, '0, '0, encode(OP_SLT, 5'd1, 1'b0, 16'd2 << 0, 5'd8));
    send_beat(CMD_EXEC, '0, '0, encode(OP_SLE, 5'd2, 1'b0, 16'd2, 5'd9));
    send_beat(CMD_EXEC, '0, '0, encode(OP_SEQ, 5'd2, 1'b0, 16'd2, 5'd10));
    send_beat(CMD_EXEC, '0, '0, {OP_JMP, 1'b1, 21'h1fffff, 5'd11});
    send_beat(CMD_EXEC, '0, '0, {OP_BRAZ, 5'd0, 22'h3fffff});
    send_beat(CMD_EXEC, '0, '0, {OP_BRANZ, 5'd2, 22'h000005});
    send_beat(CMD_EXEC, '0, '0, {5'd31, 27'h7ffffff});
    send_beat(CMD_WREG, 10'd0, 32'd0, '0);

    // random: reset-free so halt is lifted only by a fresh run; keep halt rare
    for (k = 0; k < 1530; k++) begin
      calm = (k >= 600 && k < 800);
      hold_request = (k == 900);
      case ($urandom_range(9))
        0: send_beat(CMD_WDATA, 10'($urandom), $urandom, $urandom);
        1: send_beat(CMD_WREG, 10'($urandom_range(31, 1)), $urandom, $urandom);
        2: send_beat(CMD_WDATA, 10'($urandom_range(15)), $urandom, $urandom);
        default: send_beat(CMD_EXEC, 10'($urandom), $urandom, random_instruction());
      endcase
      if (k == 901) hold_request = 1'b0;
    end
    calm = 1'b0;

    // halt, then an execute that must be ignored
    send_beat(CMD_EXEC, '0, '0, {OP_STOP, 27'd0});
    send_beat(CMD_EXEC, '0, '0, encode(OP_ADD, 5'd1, 1'b1, 16'd1, 5'd12));
    in_valid <= 1'b0;

    // drain and settle
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
src/sre_pkg.sv
src/sre_regfile.sv
src/sre_divider.sv
src/small_risc_execute_unit.sv
sim/sre_checker.sv
sim/tb.sv
